// ===== sv/fixed_point_dft_defines.svh =====
// Assertion macros shared by the fixed-point DFT design.
`ifndef FIXED_POINT_DFT_DEFINES_SVH
`define FIXED_POINT_DFT_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define FPDFT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define FPDFT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/fpdft_pkg.sv =====
// Types, constants and arithmetic helpers for the fixed-point DFT.
`timescale 1ns / 1ps

package fpdft_pkg;

   // Block size and field widths.
   localparam int POINTS     = 64;
   localparam int IDX_W      = 6;
   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = 24;
   localparam int POWER_W    = 46;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 104;

   localparam logic [IDX_W-1:0] BIN_LAST = IDX_W'(POINTS - 1);

   // Quarter-wave twiddle table: round(32767 * cos(2*pi*m/POINTS)), m = 0 .. POINTS/4.
   localparam int QUARTER = POINTS / 4;
   localparam int QTR_W   = 5;
   localparam logic signed [SAMPLE_W-1:0] QUARTER_TABLE [0:QUARTER] = '{
      16'sd32767, 16'sd32609, 16'sd32137, 16'sd31356, 16'sd30273, 16'sd28898,
      16'sd27245, 16'sd25329, 16'sd23170, 16'sd20787, 16'sd18204, 16'sd15446,
      16'sd12539, 16'sd9512,  16'sd6393,  16'sd3212,  16'sd0
   };

   // Q15 product limits.
   localparam logic signed [2*SAMPLE_W-1:0] PRODUCT_SAT = 32'sh4000_0000;
   localparam logic signed [SAMPLE_W-1:0]   SAMPLE_MAX  = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0]   SAMPLE_MIN  = 16'sh8000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] cos_val;
      logic signed [SAMPLE_W-1:0] sin_val;
   } twiddle_type;

   // Control tag that travels with each term through the MAC pipeline.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctrl_type;

   // Full-circle twiddle pair built from the quarter table by quadrant symmetry.
   function automatic twiddle_type twiddle(input logic [IDX_W-1:0] idx);
      logic [1:0]                 quad;
      logic [QTR_W-1:0]           near_idx;
      logic [QTR_W-1:0]           far_idx;
      logic signed [SAMPLE_W-1:0] near_val;
      logic signed [SAMPLE_W-1:0] far_val;
      twiddle_type                tw;
      quad     = idx[IDX_W-1 -: 2];
      near_idx = {1'b0, idx[IDX_W-3:0]};
      far_idx  = QTR_W'(QUARTER) - near_idx;
      near_val = QUARTER_TABLE[near_idx];
      far_val  = QUARTER_TABLE[far_idx];
      unique case (quad)
         2'd0: begin
            tw.cos_val = near_val;
            tw.sin_val = far_val;
         end
         2'd1: begin
            tw.cos_val = -far_val;
            tw.sin_val = near_val;
         end
         2'd2: begin
            tw.cos_val = -near_val;
            tw.sin_val = -far_val;
         end
         default: begin
            tw.cos_val = far_val;
            tw.sin_val = -near_val;
         end
      endcase
      return tw;
   endfunction

   // Q15 multiply with floor shift; the one overflowing product saturates.
   function automatic logic signed [SAMPLE_W-1:0] smpy(
      input logic signed [SAMPLE_W-1:0] a,
      input logic signed [SAMPLE_W-1:0] b
   );
      logic signed [2*SAMPLE_W-1:0] prod;
      prod = a * b;
      if (prod == PRODUCT_SAT) begin
         return SAMPLE_MAX;
      end
      return prod[2*SAMPLE_W-2:SAMPLE_W-1];
   endfunction

endpackage

// ===== sv/fixed_point_dft.sv =====
// Top level of the fixed-point direct DFT: sample chain, sequencer and result register.
//
//   Channel   Direction  Transfer holds
//   req_*     in         one complex Q15 sample
//   rsp_*     out        one frequency bin: index, real, imaginary, power
//
// A sample that does not close a block is shifted into the chain and counted. The one that
// closes it starts the bins: each bin rotates the 64-cell chain once past the MAC unit, drains
// the pipeline and writes the result. Synchronous reset clears the sequencer, the fill count
// and the result valid, not the chain. A stalled rsp_tready holds the result and stops the
// sequencer at write-back; new samples are taken once the last bin is written.
`timescale 1ns / 1ps
`include "fixed_point_dft_defines.svh"

module fixed_point_dft (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // sample_real [15:0], sample_imag [31:16]
   input  logic [fpdft_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // bin_index [5:0], real_part [29:6], imag_part [53:30], power [99:54], zero pad
   output logic [fpdft_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast
);
   import fpdft_pkg::*;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_CALC,
      ST_WAIT,
      ST_WRITE
   } state_type;

   state_type                  state_ff;
   state_type                  state_in;
   logic [IDX_W-1:0]           load_count_ff;
   logic [IDX_W-1:0]           load_count_in;
   logic [IDX_W-1:0]           bin_ff;
   logic [IDX_W-1:0]           bin_in;
   logic [IDX_W-1:0]           term_ff;
   logic [IDX_W-1:0]           term_in;
   logic [IDX_W-1:0]           phase_ff;
   logic [IDX_W-1:0]           phase_in;
   mac_ctrl_type               ctrl0_ff;
   mac_ctrl_type               ctrl0_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       rsp_load;

   logic signed [SAMPLE_W-1:0] real0_ff;
   logic signed [SAMPLE_W-1:0] imag0_ff;
   twiddle_type                tw0_ff;
   logic [IDX_W-1:0]           rsp_bin_ff;
   logic signed [SUM_W-1:0]    rsp_real_ff;
   logic signed [SUM_W-1:0]    rsp_imag_ff;
   logic [POWER_W-1:0]         rsp_power_ff;
   logic                       rsp_last_ff;

   logic                       req_accept;
   logic                       rsp_free;
   logic                       shift_en;
   logic signed [SAMPLE_W-1:0] tail_real;
   logic signed [SAMPLE_W-1:0] tail_imag;
   logic signed [SAMPLE_W-1:0] ring_real [0:POINTS-1];
   logic signed [SAMPLE_W-1:0] ring_imag [0:POINTS-1];

   logic                       mac_done;
   logic signed [SUM_W-1:0]    mac_real;
   logic signed [SUM_W-1:0]    mac_imag;
   logic [POWER_W-1:0]         mac_power;

   // Handshake terms.
   assign req_tready = (state_ff == ST_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // The chain shifts on every sample transfer and rotates while a bin is summed.
   assign shift_en  = req_accept || (state_ff == ST_CALC);
   assign tail_real = (state_ff == ST_CALC) ? ring_real[0] : req_tdata[SAMPLE_W-1:0];
   assign tail_imag = (state_ff == ST_CALC) ? ring_imag[0] : req_tdata[2*SAMPLE_W-1:SAMPLE_W];

   // Sample chain: cell 0 is the head read by the MAC, the last cell takes the tail.
   for (genvar i = 0; i < POINTS; i++) begin : g_cell
      if (i == POINTS - 1) begin : g_tail
         fpdft_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .in_real  (tail_real),
            .in_imag  (tail_imag),
            .out_real (ring_real[i]),
            .out_imag (ring_imag[i])
         );
      end else begin : g_body
         fpdft_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .in_real  (ring_real[i+1]),
            .in_imag  (ring_imag[i+1]),
            .out_real (ring_real[i]),
            .out_imag (ring_imag[i])
         );
      end
   end

   // Sequencer: fill the block, then sum each bin over one rotation and write it out.
   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      bin_in        = bin_ff;
      term_in       = term_ff;
      phase_in      = phase_ff;
      ctrl0_in      = '0;
      rsp_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (load_count_ff == BIN_LAST) begin
                  load_count_in = '0;
                  bin_in        = '0;
                  term_in       = '0;
                  phase_in      = '0;
                  state_in      = ST_CALC;
               end else begin
                  load_count_in = load_count_ff + 1'b1;
               end
            end
         end
         ST_CALC: begin
            ctrl0_in.valid = 1'b1;
            ctrl0_in.first = (term_ff == '0);
            ctrl0_in.last  = (term_ff == BIN_LAST);
            term_in        = term_ff + 1'b1;
            phase_in       = phase_ff + bin_ff;
            if (term_ff == BIN_LAST) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (mac_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (rsp_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               bin_in       = bin_ff + 1'b1;
               term_in      = '0;
               phase_in     = '0;
               state_in     = (bin_ff == BIN_LAST) ? ST_LOAD : ST_CALC;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_count_ff <= '0;
         bin_ff        <= '0;
         term_ff       <= '0;
         phase_ff      <= '0;
         ctrl0_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         bin_ff        <= bin_in;
         term_ff       <= term_in;
         phase_ff      <= phase_in;
         ctrl0_ff      <= ctrl0_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Operand stage: head sample and twiddle for the current term.
   always_ff @(posedge clock) begin
      real0_ff <= ring_real[0];
      imag0_ff <= ring_imag[0];
      tw0_ff   <= twiddle(phase_ff);
   end

   fpdft_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl0_ff),
      .sample_real (real0_ff),
      .sample_imag (imag0_ff),
      .cos_val     (tw0_ff.cos_val),
      .sin_val     (tw0_ff.sin_val),
      .done        (mac_done),
      .sum_real    (mac_real),
      .sum_imag    (mac_imag),
      .power       (mac_power)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_bin_ff   <= bin_ff;
         rsp_real_ff  <= mac_real;
         rsp_imag_ff  <= mac_imag;
         rsp_power_ff <= mac_power;
         rsp_last_ff  <= (bin_ff == BIN_LAST);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0, rsp_power_ff, rsp_imag_ff, rsp_real_ff, rsp_bin_ff};

   // The final bin of a block is the one marked last.
   `FPDFT_ASSERT_NOW(a_last_bin, rsp_valid_ff && rsp_last_ff, rsp_bin_ff == BIN_LAST, "last flag on wrong bin")

   // The fill count is back at zero whenever bins are being worked out.
   `FPDFT_ASSERT_NOW(a_count_idle, state_ff != ST_LOAD, load_count_ff == '0, "fill count not cleared")

   // A finished bin arrives only while the sequencer waits for it.
   `FPDFT_ASSERT_NOW(a_done_wait, mac_done, state_ff == ST_WAIT, "bin finished outside wait")

   // A finished bin is always followed by write-back.
   `FPDFT_ASSERT_NEXT(a_done_write, mac_done, state_ff == ST_WRITE, "bin not written back")

endmodule

// ===== sv/fpdft_cell.sv =====
// One sample cell of the rotating sample chain.
`timescale 1ns / 1ps

module fpdft_cell (
   input  logic                                    clock,
   input  logic                                    shift_en,
   input  logic signed [fpdft_pkg::SAMPLE_W-1:0]   in_real,
   input  logic signed [fpdft_pkg::SAMPLE_W-1:0]   in_imag,
   output logic signed [fpdft_pkg::SAMPLE_W-1:0]   out_real,
   output logic signed [fpdft_pkg::SAMPLE_W-1:0]   out_imag
);
   import fpdft_pkg::*;

   logic signed [SAMPLE_W-1:0] real_ff;
   logic signed [SAMPLE_W-1:0] imag_ff;
   logic signed [SAMPLE_W-1:0] real_in;
   logic signed [SAMPLE_W-1:0] imag_in;

   // Take the neighbour's sample on a shift, otherwise hold.
   always_comb begin
      real_in = shift_en ? in_real : real_ff;
      imag_in = shift_en ? in_imag : imag_ff;
   end

   always_ff @(posedge clock) begin
      real_ff <= real_in;
      imag_ff <= imag_in;
   end

   assign out_real = real_ff;
   assign out_imag = imag_ff;

endmodule

// ===== sv/fpdft_mac.sv =====
// Complex multiply-accumulate pipeline with power computation for one bin.
`timescale 1ns / 1ps

module fpdft_mac (
   input  logic                                    clock,
   input  logic                                    reset,
   input  fpdft_pkg::mac_ctrl_type                 ctrl,
   input  logic signed [fpdft_pkg::SAMPLE_W-1:0]   sample_real,
   input  logic signed [fpdft_pkg::SAMPLE_W-1:0]   sample_imag,
   input  logic signed [fpdft_pkg::SAMPLE_W-1:0]   cos_val,
   input  logic signed [fpdft_pkg::SAMPLE_W-1:0]   sin_val,
   output logic                                    done,
   output logic signed [fpdft_pkg::SUM_W-1:0]      sum_real,
   output logic signed [fpdft_pkg::SUM_W-1:0]      sum_imag,
   output logic [fpdft_pkg::POWER_W-1:0]           power
);
   import fpdft_pkg::*;

   localparam int SQ_W = 2 * SUM_W;

   mac_ctrl_type               ctrl1_ff;
   logic                       done2_ff;
   logic                       done3_ff;
   logic                       done4_ff;
   logic signed [SAMPLE_W-1:0] rc_ff;
   logic signed [SAMPLE_W-1:0] is_ff;
   logic signed [SAMPLE_W-1:0] ns_ff;
   logic signed [SAMPLE_W-1:0] ic_ff;
   logic signed [SAMPLE_W-1:0] neg_real;
   logic signed [SUM_W-1:0]    acc_real_ff;
   logic signed [SUM_W-1:0]    acc_imag_ff;
   logic signed [SUM_W-1:0]    acc_real_in;
   logic signed [SUM_W-1:0]    acc_imag_in;
   logic signed [SUM_W-1:0]    base_real;
   logic signed [SUM_W-1:0]    base_imag;
   logic signed [SQ_W-1:0]     sq_real_full;
   logic signed [SQ_W-1:0]     sq_imag_full;
   logic [POWER_W-1:0]         sq_real_ff;
   logic [POWER_W-1:0]         sq_imag_ff;
   logic [POWER_W-1:0]         power_ff;

   // Negated real part; the most negative sample saturates.
   assign neg_real = (sample_real == SAMPLE_MIN) ? SAMPLE_MAX : -sample_real;

   // Stage 1: the four Q15 products of one term.
   always_ff @(posedge clock) begin
      rc_ff <= smpy(sample_real, cos_val);
      is_ff <= smpy(sample_imag, sin_val);
      ns_ff <= smpy(neg_real, sin_val);
      ic_ff <= smpy(sample_imag, cos_val);
   end

   // Stage 2: accumulate, restarting on the first term of a bin.
   always_comb begin
      base_real   = ctrl1_ff.first ? '0 : acc_real_ff;
      base_imag   = ctrl1_ff.first ? '0 : acc_imag_ff;
      acc_real_in = base_real + SUM_W'(rc_ff) + SUM_W'(is_ff);
      acc_imag_in = base_imag + SUM_W'(ns_ff) + SUM_W'(ic_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl1_ff.valid) begin
         acc_real_ff <= acc_real_in;
         acc_imag_ff <= acc_imag_in;
      end
   end

   // Stage 3: squares of the finished sums; both stay below 2^45.
   assign sq_real_full = acc_real_ff * acc_real_ff;
   assign sq_imag_full = acc_imag_ff * acc_imag_ff;

   always_ff @(posedge clock) begin
      if (done2_ff) begin
         sq_real_ff <= sq_real_full[POWER_W-1:0];
         sq_imag_ff <= sq_imag_full[POWER_W-1:0];
      end
   end

   // Stage 4: power.
   always_ff @(posedge clock) begin
      if (done3_ff) begin
         power_ff <= sq_real_ff + sq_imag_ff;
      end
   end

   // Control tags through the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff <= '0;
         done2_ff <= 1'b0;
         done3_ff <= 1'b0;
         done4_ff <= 1'b0;
      end else begin
         ctrl1_ff <= ctrl;
         done2_ff <= ctrl1_ff.valid && ctrl1_ff.last;
         done3_ff <= done2_ff;
         done4_ff <= done3_ff;
      end
   end

   assign done     = done4_ff;
   assign sum_real = acc_real_ff;
   assign sum_imag = acc_imag_ff;
   assign power    = power_ff;

endmodule

// ===== test/dft_bin_checker.sv =====
// Bin checker for the fixed-point DFT: predicts every frequency bin and compares the results.
`timescale 1ns / 1ps

module dft_bin_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [fpdft_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [fpdft_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                rsp_tlast,
   output int                                  failures,
   output int                                  bins_outstanding,
   output int                                  bins_checked,
   output int                                  blocks_loaded
);

   import fpdft_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0]          bin;
      logic signed [SUM_W-1:0]   re_sum;
      logic signed [SUM_W-1:0]   im_sum;
      logic [POWER_W-1:0]        power;
      logic                      last;
   } bin_result_type;

   // Twiddle tables and the checker's own copy of the collected samples.
   logic signed [SAMPLE_W-1:0] cos_q15 [0:POINTS-1];
   logic signed [SAMPLE_W-1:0] sin_q15 [0:POINTS-1];
   logic signed [SAMPLE_W-1:0] re_samples [0:POINTS-1];
   logic signed [SAMPLE_W-1:0] im_samples [0:POINTS-1];
   int                         fill_pos;
   bin_result_type             bins_due [$];

   // Round half away from zero of 32767 times the cosine and sine of each angle.
   initial begin : build_twiddles
      real angle;
      real scaled;
      for (int m = 0; m < POINTS; m++) begin
         angle  = 2.0 * 3.14159265358979323846 * m / POINTS;
         scaled = 32767.0 * $cos(angle);
         cos_q15[IDX_W'(m)] = (scaled >= 0.0) ? SAMPLE_W'($rtoi(scaled + 0.5))
                                              : SAMPLE_W'(-$rtoi(0.5 - scaled));
         scaled = 32767.0 * $sin(angle);
         sin_q15[IDX_W'(m)] = (scaled >= 0.0) ? SAMPLE_W'($rtoi(scaled + 0.5))
                                              : SAMPLE_W'(-$rtoi(0.5 - scaled));
      end
   end

   // Q15 product, floored; only the product of two most negative values overflows.
   function automatic logic signed [SAMPLE_W-1:0] q15_product(
      input logic signed [SAMPLE_W-1:0] a,
      input logic signed [SAMPLE_W-1:0] b
   );
      logic signed [2*SAMPLE_W-1:0] full;
      full = a * b;
      if (full == 32'sh4000_0000) begin
         return 16'sh7FFF;
      end
      return SAMPLE_W'(full >>> (SAMPLE_W - 1));
   endfunction

   // Direct DFT of the collected block: one expected result per bin, in bin order.
   function automatic void compute_spectrum();
      int                         re_acc;
      int                         im_acc;
      logic [IDX_W-1:0]           idx;
      logic [IDX_W-1:0]           pos;
      logic signed [SAMPLE_W-1:0] neg_re;
      longint                     pw;
      bin_result_type             res;
      for (int n = 0; n < POINTS; n++) begin
         re_acc = 0;
         im_acc = 0;
         for (int k = 0; k < POINTS; k++) begin
            idx = IDX_W'((n * k) % POINTS);
            pos = IDX_W'(k);
            // Negating the most negative sample saturates.
            neg_re = (re_samples[pos] == 16'sh8000) ? 16'sh7FFF : -re_samples[pos];
            re_acc += q15_product(re_samples[pos], cos_q15[idx]);
            re_acc += q15_product(im_samples[pos], sin_q15[idx]);
            im_acc += q15_product(neg_re, sin_q15[idx]);
            im_acc += q15_product(im_samples[pos], cos_q15[idx]);
         end
         pw = longint'(re_acc) * re_acc + longint'(im_acc) * im_acc;
         res.bin    = IDX_W'(n);
         res.re_sum = SUM_W'(re_acc);
         res.im_sum = SUM_W'(im_acc);
         res.power  = pw[POWER_W-1:0];
         res.last   = (n == POINTS - 1);
         bins_due.push_back(res);
      end
   endfunction

   // Watch both channels at each rising edge.
   always @(posedge clock) begin : watch
      bin_result_type want;
      if (reset) begin
         fill_pos = 0;
         bins_due.delete();
      end else begin
         // A sample transfer fills the next position; the last one closes the block.
         if (req_tvalid && req_tready) begin
            re_samples[IDX_W'(fill_pos)] = req_tdata[SAMPLE_W-1:0];
            im_samples[IDX_W'(fill_pos)] = req_tdata[2*SAMPLE_W-1:SAMPLE_W];
            if (fill_pos == POINTS - 1) begin
               compute_spectrum();
               fill_pos = 0;
               blocks_loaded++;
            end else begin
               fill_pos++;
            end
         end
         // A result transfer is compared with the oldest expected bin.
         if (rsp_tvalid && rsp_tready) begin
            if (bins_due.size() == 0) begin
               $error("Unexpected result transfer for bin %0d", rsp_tdata[5:0]);
               failures++;
            end else begin
               want = bins_due.pop_front();
               bins_checked++;
               if (rsp_tdata[5:0] !== want.bin) begin
                  $error("bin_index mismatch: expected %0d, actual %0d",
                         want.bin, rsp_tdata[5:0]);
                  failures++;
               end
               if ($signed(rsp_tdata[29:6]) !== want.re_sum) begin
                  $error("real_part mismatch: expected %0d, actual %0d",
                         want.re_sum, $signed(rsp_tdata[29:6]));
                  failures++;
               end
               if ($signed(rsp_tdata[53:30]) !== want.im_sum) begin
                  $error("imag_part mismatch: expected %0d, actual %0d",
                         want.im_sum, $signed(rsp_tdata[53:30]));
                  failures++;
               end
               if (rsp_tdata[99:54] !== want.power) begin
                  $error("power mismatch: expected %0d, actual %0d",
                         want.power, rsp_tdata[99:54]);
                  failures++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_bin mismatch: expected %0d, actual %0d",
                         want.last, rsp_tlast);
                  failures++;
               end
            end
         end
      end
      bins_outstanding <= bins_due.size();
   end

   initial begin
      failures      = 0;
      bins_checked  = 0;
      blocks_loaded = 0;
   end

endmodule

// ===== test/testbench.sv =====
// Top of the fixed-point DFT testbench: clock, reset, sample stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

   import fpdft_pkg::*;

   localparam int BLOCK_COUNT = 4;
   localparam int EDGE_COUNT  = 25;
   localparam int EDGE_W      = $clog2(EDGE_COUNT);

   // Directed samples, imaginary part in the upper half: extremes, signs, bit patterns.
   localparam logic [REQ_DATA_W-1:0] EDGE_SAMPLES [0:EDGE_COUNT-1] = '{
      32'h0000_0000, 32'h7FFF_7FFF, 32'h8000_8000, 32'h7FFF_8000, 32'h8000_7FFF,
      32'hFFFF_FFFF, 32'h0001_0001, 32'h0000_8000, 32'h8000_0000, 32'h0000_7FFF,
      32'h7FFF_0000, 32'h0001_FFFF, 32'hFFFF_0001, 32'hC000_4000, 32'h4000_C000,
      32'hAAAA_5555, 32'h5555_AAAA, 32'hFFFF_8000, 32'h8000_FFFF, 32'h0001_7FFF,
      32'h0002_FFFE, 32'hFF00_0100, 32'h8000_8000, 32'hFFFF_7FFF, 32'h0000_0000
   };

   // Kinds of sample block in the random part.
   typedef enum int {
      BLOCK_UNIFORM,
      BLOCK_EXTREMES,
      BLOCK_SPARSE,
      BLOCK_CONSTANT
   } block_kind_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;

   int failures;
   int bins_outstanding;
   int bins_checked;
   int blocks_loaded;
   int stall_left;
   logic steady_drain;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fixed_point_dft dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   dft_bin_checker bin_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast),
      .failures         (failures),
      .bins_outstanding (bins_outstanding),
      .bins_checked     (bins_checked),
      .blocks_loaded    (blocks_loaded)
   );

   // Result side: after each transfer hold tready low for a random stall; some blocks drain
   // with no stalls at all.
   always @(posedge clock) begin : rsp_pacing
      int stall;
      if (reset) begin
         rsp_tready   <= 1'b0;
         stall_left   <= 0;
         steady_drain <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         stall = steady_drain ? 0 : $urandom_range(0, 13);
         if (rsp_tlast) begin
            steady_drain <= ($urandom_range(0, 3) == 0);
         end
         rsp_tready <= (stall == 0);
         stall_left <= stall;
      end else if (!rsp_tready) begin
         if (stall_left <= 1) begin
            rsp_tready <= 1'b1;
         end
         stall_left <= stall_left - 1;
      end
   end

   // One sample transfer, preceded by the given number of idle cycles.
   task automatic send_sample(input logic [REQ_DATA_W-1:0] word, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
   endtask

   // One Q15 value of a block of the given kind.
   function automatic logic [SAMPLE_W-1:0] draw_value(input block_kind_type kind,
                                                      input logic [SAMPLE_W-1:0] fill);
      logic [SAMPLE_W-1:0] picks [0:4];
      picks = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
      unique case (kind)
         BLOCK_EXTREMES: begin
            return picks[3'($urandom_range(0, 4))];
         end
         BLOCK_SPARSE: begin
            return ($urandom_range(0, 7) == 0) ? SAMPLE_W'($urandom) : '0;
         end
         BLOCK_CONSTANT: begin
            return fill;
         end
         default: begin
            return SAMPLE_W'($urandom);
         end
      endcase
   endfunction

   initial begin : stimulus
      block_kind_type        kind;
      logic [SAMPLE_W-1:0]   fill_re;
      logic [SAMPLE_W-1:0]   fill_im;
      logic                  steady_feed;
      int                    gap;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int b = 0; b < BLOCK_COUNT; b++) begin
         // The first block opens with the directed samples; later ones cycle the kinds.
         unique case (b)
            1:       kind = BLOCK_EXTREMES;
            2:       kind = BLOCK_SPARSE;
            3:       kind = BLOCK_CONSTANT;
            default: kind = BLOCK_UNIFORM;
         endcase
         fill_re     = SAMPLE_W'($urandom);
         fill_im     = SAMPLE_W'($urandom);
         steady_feed = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < POINTS; k++) begin
            gap = steady_feed ? 0 : $urandom_range(0, 13);
            if (b == 0 && k < EDGE_COUNT) begin
               send_sample(EDGE_SAMPLES[EDGE_W'(k)], gap);
            end else begin
               send_sample({draw_value(kind, fill_im), draw_value(kind, fill_re)}, gap);
            end
         end
      end
      req_tvalid <= 1'b0;

      // Let the last block's bins drain, then allow for any late stray transfer.
      @(posedge clock);
      while (bins_outstanding != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Loaded %0d sample blocks (%0d samples), directed extremes first.",
               blocks_loaded, blocks_loaded * POINTS);
      $display("Checked %0d frequency bins with random stalls on both channels.",
               bins_checked);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
